// ===== rtl/slm_pkg.sv =====
// Shared constants and types for the strict 3x3 local-maximum unit.
// Used by slm_linebuf, slm_emit and strict_local_max_3x3_unit; no dependencies.
package slm_pkg;

  // Configuration port
  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_TOTAL = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COL_TOTAL = 1'd1;

  // Position fields and counters
  localparam int POS_BITS = 10;

  // Defaults for the top-level parameters
  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;

  // Up to four centers are decided by one input beat
  localparam int N_CAND   = 4;
  localparam int SEL_BITS = $clog2(N_CAND);

  // Per-result control fields, handed from the compare stage to the emitter
  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                peak;
    logic                last;
  } res_info_t;

endpackage

// ===== rtl/slm_linebuf.sv =====
// Two-row line buffer held in one synchronous memory: {older row, newer row}.
// Registered read, with forwarding of a same-cycle write to the same column.
// Depends on slm_pkg for the parameter defaults.
module slm_linebuf #(
  parameter int MAX_COLS   = slm_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = slm_pkg::VALUE_BITS_DEF,
  parameter int ADDR_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [ADDR_BITS-1:0]    rd_addr,
  input  logic                    wr_en,
  input  logic [ADDR_BITS-1:0]    wr_addr,
  input  logic [2*VALUE_BITS-1:0] wr_data,
  output logic [2*VALUE_BITS-1:0] rd_data
);

  logic [2*VALUE_BITS-1:0] mem [MAX_COLS];
  logic [2*VALUE_BITS-1:0] rd_q;
  logic [2*VALUE_BITS-1:0] fwd_data;
  logic                    fwd;

  // Memory port: write-back of the previous beat, read for the new beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // Read and write hit the same column on the same edge: memory returns stale data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : rd_q;

  // A forward is only ever armed by a write on the read edge
  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(fwd) |-> $past(wr_en))
    else $error("forward armed without a colliding write");

endmodule

// ===== rtl/slm_emit.sv =====
// Result emitter: holds the up to four results of one beat and sends them one per cycle
// through the output register unless stalled; tracks whether the frame had a peak.
// Depends on slm_pkg (res_info_t, N_CAND, SEL_BITS, POS_BITS).
module slm_emit #(
  parameter int VALUE_BITS = slm_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clr,
  input  logic                            grp_valid,
  input  logic [slm_pkg::N_CAND-1:0]      grp_mask,
  input  logic signed [VALUE_BITS-1:0]    grp_value [slm_pkg::N_CAND],
  input  slm_pkg::res_info_t              grp_info  [slm_pkg::N_CAND],
  output logic                            take,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [VALUE_BITS-1:0]    center_value,
  output logic [slm_pkg::POS_BITS-1:0]    center_row,
  output logic [slm_pkg::POS_BITS-1:0]    center_col,
  output logic                            is_peak,
  output logic                            frame_end,
  output logic                            any_peak
);
  import slm_pkg::*;

  logic [N_CAND-1:0]            mask;
  logic [N_CAND-1:0]            mask_after;
  logic signed [VALUE_BITS-1:0] val_q  [N_CAND];
  res_info_t                    info_q [N_CAND];
  logic [SEL_BITS-1:0]          sel;
  logic                         out_free;
  logic                         pop;
  logic                         peak_seen;

  // Lowest pending result goes first (row-major order of centers)
  always_comb begin
    sel = '0;
    for (int k = N_CAND - 1; k >= 0; k--) begin
      if (mask[k]) begin
        sel = SEL_BITS'(k);
      end
    end
  end

  assign out_free   = !out_valid || !out_stall;
  assign pop        = out_free && (|mask);
  assign mask_after = pop ? (mask & ~(N_CAND'(1) << sel)) : mask;
  assign take       = (mask_after == '0);

  // Pending mask
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (take) begin
      mask <= grp_valid ? grp_mask : '0;
    end else begin
      mask <= mask_after;
    end
  end

  // Group payload
  always_ff @(posedge clk) begin
    if (take && grp_valid) begin
      val_q  <= grp_value;
      info_q <= grp_info;
    end
  end

  // Frame peak tracking, in result order
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      peak_seen <= 1'b0;
    end else if (pop) begin
      if (info_q[sel].last) begin
        peak_seen <= 1'b0;
      end else if (info_q[sel].peak) begin
        peak_seen <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      center_value <= val_q[sel];
      center_row   <= info_q[sel].row;
      center_col   <= info_q[sel].col;
      is_peak      <= info_q[sel].peak;
      frame_end    <= info_q[sel].last;
      any_peak     <= info_q[sel].last && (peak_seen || info_q[sel].peak);
    end
  end

  a_any_peak_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!any_peak || frame_end))
    else $error("any_peak set on a beat without frame_end");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && (|mask)) |-> !take)
    else $error("new group taken while results are still pending");

endmodule

// ===== rtl/strict_local_max_3x3_unit.sv =====
// Strict 3x3 local-maximum unit: row-major signed stream in, one result per decided center.
// Path: stage 1 (line buffer read), stage 2 (window compare), emitter, output register.
// Throughput: one input beat per cycle unless stalled; a beat that decides k > 1 centers
// stalls the input until its last result enters the single output register (one per cycle).
// Reset (rst, synchronous): control, counters and window cleared, row/col totals = 1;
// the line buffer memory is not cleared and needs no clearing pass.
module strict_local_max_3x3_unit #(
  parameter int MAX_COLS   = slm_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = slm_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS = slm_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [slm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [slm_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [VALUE_BITS-1:0]        pixel_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [VALUE_BITS-1:0]        center_value,
  output logic [slm_pkg::POS_BITS-1:0]        center_row,
  output logic [slm_pkg::POS_BITS-1:0]        center_col,
  output logic                                is_peak,
  output logic                                frame_end,
  output logic                                any_peak
);
  import slm_pkg::*;

  localparam int ADDR_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Configuration
  logic [CFG_BITS-1:0] row_total;
  logic [CFG_BITS-1:0] col_total;
  logic [CFG_BITS-1:0] rows_eff;
  logic [CFG_BITS-1:0] cols_eff;
  logic [CFG_BITS-1:0] rows_m1;
  logic [CFG_BITS-1:0] cols_m1;

  // Input position
  logic [POS_BITS-1:0] row_cnt;
  logic [POS_BITS-1:0] col_cnt;
  logic                last_row;
  logic                last_col;

  // Pipeline control
  logic adv;
  logic accept;

  // Stage 1: line buffer data returns
  logic                         s1_valid;
  logic signed [VALUE_BITS-1:0] s1_pix;
  logic [POS_BITS-1:0]          s1_i;
  logic [POS_BITS-1:0]          s1_j;
  logic                         s1_last_row;
  logic                         s1_last_col;
  logic [2*VALUE_BITS-1:0]      lb_rd;
  logic signed [VALUE_BITS-1:0] older_col;
  logic signed [VALUE_BITS-1:0] newer_col;

  // Stage 2: window compare
  logic                         s2_valid;
  logic [POS_BITS-1:0]          s2_i;
  logic [POS_BITS-1:0]          s2_j;
  logic                         s2_last_row;
  logic                         s2_last_col;
  logic signed [VALUE_BITS-1:0] win [9];

  logic [N_CAND-1:0]            grp_mask;
  logic signed [VALUE_BITS-1:0] grp_value [N_CAND];
  res_info_t                    grp_info  [N_CAND];

  // Strict peak test of the window cell (wr, wc) against its in-window neighbours;
  // up_ok / left_ok say whether the row above / column to the left lie in the matrix.
  function automatic logic peak_at(input int wr, input int wc,
                                   input logic up_ok, input logic left_ok,
                                   input logic signed [VALUE_BITS-1:0] w [9]);
    logic signed [VALUE_BITS-1:0] cen;
    logic                         pk;
    cen = w[wr*3 + wc];
    pk  = 1'b1;
    for (int nr = 0; nr < 3; nr++) begin
      for (int nc = 0; nc < 3; nc++) begin
        if (nr >= wr - 1 && nr <= wr + 1 && nc >= wc - 1 && nc <= wc + 1 &&
            !(nr == wr && nc == wc) &&
            (nr >= wr || up_ok) && (nc >= wc || left_ok) &&
            !(cen > w[nr*3 + nc])) begin
          pk = 1'b0;
        end
      end
    end
    return pk;
  endfunction

  // Totals clamped to 1..MAX
  always_comb begin
    if (row_total == '0) begin
      rows_eff = CFG_BITS'(1);
    end else if (int'(row_total) > MAX_ROWS) begin
      rows_eff = CFG_BITS'(MAX_ROWS);
    end else begin
      rows_eff = row_total;
    end
    if (col_total == '0) begin
      cols_eff = CFG_BITS'(1);
    end else if (int'(col_total) > MAX_COLS) begin
      cols_eff = CFG_BITS'(MAX_COLS);
    end else begin
      cols_eff = col_total;
    end
    rows_m1 = rows_eff - CFG_BITS'(1);
    cols_m1 = cols_eff - CFG_BITS'(1);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_total <= CFG_BITS'(1);
      col_total <= CFG_BITS'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_TOTAL: row_total <= cfg_data;
        REG_COL_TOTAL: col_total <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && adv;
  assign in_stall = !adv;
  assign last_row = ({1'b0, row_cnt} >= rows_m1);
  assign last_col = ({1'b0, col_cnt} >= cols_m1);

  // Position counters; any config write restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + POS_BITS'(1);
      end else begin
        col_cnt <= col_cnt + POS_BITS'(1);
      end
    end
  end

  // Line buffer: read at accept, write back {newer -> older, pixel -> newer} in stage 1
  slm_linebuf #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_linebuf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ADDR_BITS'(col_cnt)),
    .wr_en   (s1_valid && adv),
    .wr_addr (ADDR_BITS'(s1_j)),
    .wr_data ({newer_col, s1_pix}),
    .rd_data (lb_rd)
  );

  assign older_col = $signed(lb_rd[2*VALUE_BITS-1:VALUE_BITS]);
  assign newer_col = $signed(lb_rd[VALUE_BITS-1:0]);

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixel_value;
      s1_i        <= row_cnt;
      s1_j        <= col_cnt;
      s1_last_row <= last_row;
      s1_last_col <= last_col;
    end
    if (adv && s1_valid) begin
      s2_i        <= s1_i;
      s2_j        <= s1_j;
      s2_last_row <= s1_last_row;
      s2_last_col <= s1_last_col;
    end
  end

  // 3x3 window: shift left, new column {older, newer, pixel} on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (adv && s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]     <= win[k*3 + 1];
        win[k*3 + 1] <= win[k*3 + 2];
      end
      win[2] <= older_col;
      win[5] <= newer_col;
      win[8] <= s1_pix;
    end
  end

  // Candidate centers: (i-1, j-1), (i-1, j), (i, j-1), (i, j)
  always_comb begin
    logic                up_prev;
    logic                up_cur;
    logic                left_prev;
    logic                left_cur;
    logic [POS_BITS-1:0] r_prev;
    logic [POS_BITS-1:0] c_prev;
    up_prev   = (s2_i > POS_BITS'(1));
    up_cur    = (s2_i != '0);
    left_prev = (s2_j > POS_BITS'(1));
    left_cur  = (s2_j != '0);
    r_prev    = s2_i - POS_BITS'(1);
    c_prev    = s2_j - POS_BITS'(1);

    grp_mask[0] = up_cur && left_cur;
    grp_mask[1] = up_cur && s2_last_col;
    grp_mask[2] = s2_last_row && left_cur;
    grp_mask[3] = s2_last_row && s2_last_col;

    grp_value[0] = win[4];
    grp_value[1] = win[5];
    grp_value[2] = win[7];
    grp_value[3] = win[8];

    grp_info[0].row  = r_prev;
    grp_info[0].col  = c_prev;
    grp_info[0].peak = peak_at(1, 1, up_prev, left_prev, win);
    grp_info[1].row  = r_prev;
    grp_info[1].col  = s2_j;
    grp_info[1].peak = peak_at(1, 2, up_prev, left_cur, win);
    grp_info[2].row  = s2_i;
    grp_info[2].col  = c_prev;
    grp_info[2].peak = peak_at(2, 1, up_cur, left_prev, win);
    grp_info[3].row  = s2_i;
    grp_info[3].col  = s2_j;
    grp_info[3].peak = peak_at(2, 2, up_cur, left_cur, win);

    for (int k = 0; k < N_CAND; k++) begin
      grp_info[k].last = ({1'b0, grp_info[k].row} == rows_m1) &&
                         ({1'b0, grp_info[k].col} == cols_m1);
    end
  end

  // Result emitter and output register
  slm_emit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .clr          (cfg_write),
    .grp_valid    (s2_valid),
    .grp_mask     (grp_mask),
    .grp_value    (grp_value),
    .grp_info     (grp_info),
    .take         (adv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .center_value (center_value),
    .center_row   (center_row),
    .center_col   (center_col),
    .is_peak      (is_peak),
    .frame_end    (frame_end),
    .any_peak     (any_peak)
  );

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_cnt} <= cols_m1) && ({1'b0, row_cnt} <= rows_m1))
    else $error("input position outside the configured frame");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted beat did not enter stage 1");

endmodule
